[hw/rtl/integer_square_root_unit_assert.svh]
// assertion macros used by the square root unit controller
`ifndef INTEGER_SQUARE_ROOT_UNIT_ASSERT_SVH
`define INTEGER_SQUARE_ROOT_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define ISQRT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("isqrt assertion failed");

// next-cycle implication, clocked on clk, off while arst_n is low
`define ISQRT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("isqrt assertion failed");

`endif

[hw/rtl/isqrt_pkg.sv]
`default_nettype none

package isqrt_pkg;

	// width of the root field on the port
	localparam int ROOT_W = 32;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic step;
		logic publish;
	} isqrt_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic last;
	} isqrt_sts_t;

endpackage

`default_nettype wire

[hw/rtl/isqrt_ctrl.sv]
`default_nettype none

`include "integer_square_root_unit_assert.svh"

module isqrt_ctrl
	import isqrt_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	input  wire isqrt_sts_t sts,
	output isqrt_cmd_t      cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_HOLD = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nx;
	logic       out_valid_q;
	logic       out_free;
	logic       accept;

	// output slot can take a word this cycle
	assign out_free = !out_valid_q || out_ready;

	assign in_ready = (state_q == S_IDLE) || ((state_q == S_HOLD) && out_free);
	assign accept   = in_valid && in_ready;

	assign cmd.load    = accept;
	assign cmd.step    = (state_q == S_RUN);
	assign cmd.publish = (state_q == S_HOLD) && out_free;

	assign out_valid = out_valid_q;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_nx = S_RUN;
			end
			S_RUN: begin
				if (sts.last) state_nx = S_HOLD;
			end
			S_HOLD: begin
				if (out_free) state_nx = accept ? S_RUN : S_IDLE;
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`ISQRT_ASSERT_NOW(a_no_accept_while_run, cmd.step, !in_ready)
	`ISQRT_ASSERT_NEXT(a_last_step_holds, cmd.step && sts.last, state_q == S_HOLD)
	`ISQRT_ASSERT_NEXT(a_publish_shows, cmd.publish, out_valid)

endmodule

`default_nettype wire

[hw/rtl/isqrt_dp.sv]
`default_nettype none

module isqrt_dp
	import isqrt_pkg::*;
#(
	parameter int INPUT_BITS = 63
) (
	input  wire logic                  clk,
	input  wire logic [INPUT_BITS-1:0] value,
	input  wire isqrt_cmd_t            cmd,
	output isqrt_sts_t                 sts,
	output logic [ROOT_W-1:0]          root
);

	localparam int RW    = (INPUT_BITS + 1) / 2;
	localparam int XW    = 2 * RW;
	localparam int CNT_W = (RW > 1) ? $clog2(RW) : 1;

	logic [XW-1:0]     x_q;
	logic [RW:0]       rem_q;
	logic [RW-1:0]     root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [ROOT_W-1:0] root_out_q;

	logic [RW+2:0] rem_ext;
	logic [RW+2:0] trial;
	logic [RW+2:0] diff;
	logic          keep;
	logic [RW:0]   root_nx;

	// bring down the next two input bits and try root*4+1
	assign rem_ext = {rem_q, x_q[XW-1 -: 2]};
	assign trial   = {1'b0, root_q, 2'b01};
	assign diff    = rem_ext - trial;
	assign keep    = (rem_ext >= trial);
	assign root_nx = {root_q, keep};

	assign sts.last = (cnt_q == '0);
	assign root     = root_out_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q    <= XW'(value);
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= CNT_W'(RW - 1);
		end else if (cmd.step) begin
			x_q    <= x_q << 2;
			rem_q  <= keep ? diff[RW:0] : rem_ext[RW:0];
			root_q <= root_nx[RW-1:0];
			cnt_q  <= cnt_q - 1'b1;
		end
		if (cmd.publish) begin
			root_out_q <= ROOT_W'(root_q);
		end
	end

endmodule

`default_nettype wire

[hw/rtl/integer_square_root_unit.sv]
// integer square root unit: floor(sqrt(value)) by digit-by-digit recurrence
//
// input channel: value with in_valid / in_ready, a word is taken when both are high
// output channel: root with out_valid / out_ready, same handshake
// root is the largest integer whose square does not exceed value
//
// one root bit is settled per cycle by a shared subtract-and-compare on the
// partial remainder, iterating once for each of the (INPUT_BITS+1)/2 root
// bits (32 for 63-bit input), then moving the root into the output register;
// a new word is taken in the same cycle the previous root is published, so
// the next word is not taken while the previous one is still iterating
//
// the output register lets a finished root wait while the next word is
// taken; if the receiver stalls with a root still held, the next root waits
// in the datapath and in_ready stays low until the output slot frees up
//
// reset clears the controller to idle and drops out_valid; no clearing pass
`default_nettype none

module integer_square_root_unit
	import isqrt_pkg::*;
#(
	parameter int INPUT_BITS = 63
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [INPUT_BITS-1:0] value,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [ROOT_W-1:0]          root
);

	isqrt_cmd_t cmd;
	isqrt_sts_t sts;

	// sequencer: idle, iterate, hand off to output register
	isqrt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// remainder, partial root, step counter and output register
	isqrt_dp #(
		.INPUT_BITS (INPUT_BITS)
	) u_dp (
		.clk   (clk),
		.value (value),
		.cmd   (cmd),
		.sts   (sts),
		.root  (root)
	);

endmodule

`default_nettype wire
